>>> rtl/crcdf_pkg.sv
// Shared constants, types and CRC-32C byte function for the packet deframer.
package crcdf_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CNT_W       = 6;
	localparam int LEN_W       = 16;
	localparam int LIMIT_W     = 6;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [7:0]  STX_BYTE = 8'h02;
	localparam logic [7:0]  ETX_BYTE = 8'h03;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_HDR_CRC   = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_BAD_END   = 3'd4,
		ST_DATA_CRC  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CRC_HOLD  = 2'd0,
		CRC_START = 2'd1,
		CRC_STEP  = 2'd2,
		CRC_CLEAR = 2'd3
	} crc_op_t;

	typedef struct packed {
		crc_op_t          crc_op;
		logic             len_lo_ld;
		logic             len_hi_ld;
		logic             rcrc_clr;
		logic             rcrc_ld;
		logic [CNT_W-1:0] count;
		logic             mem_wr;
		logic             mem_rd;
		logic             out_err_ld;
		status_t          err_code;
		logic             out_data_ld;
	} cmd_t;

	typedef struct packed {
		logic is_stx;
		logic is_etx;
		logic hcrc_ok;
		logic len_ok;
		logic data_done;
		logic dcrc_ok;
		logic rel_last;
	} stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/crcdf_ctrl.sv
// Frame controller: parse phases, byte counter, release sequencing, output valid.
module crcdf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  crcdf_pkg::stat_t    stat,
	output crcdf_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_HUNT,
		S_LEN_LO,
		S_LEN_HI,
		S_HCRC,
		S_DATA,
		S_DCRC,
		S_ETX,
		S_REL_READ,
		S_REL_SEND
	} state_t;

	state_t                      state_q, state_d;
	logic [crcdf_pkg::CNT_W-1:0] count_q, count_d;
	logic                        out_valid_q;
	logic                        slot_free;
	logic                        may_emit;
	logic                        accept;

	assign slot_free = !out_valid_q || out_ready;
	assign may_emit  = (state_q == S_HUNT) || (state_q == S_ETX) ||
	                   ((state_q == S_HCRC) && (count_q == crcdf_pkg::CNT_W'(3)));
	assign in_ready  = (state_q != S_REL_READ) && (state_q != S_REL_SEND) &&
	                   (slot_free || !may_emit);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		cmd              = '0;
		cmd.crc_op       = crcdf_pkg::CRC_HOLD;
		cmd.err_code     = crcdf_pkg::ST_OK;
		cmd.count        = count_q;
		case (state_q)
			S_HUNT: begin
				if (accept) begin
					if (!stat.is_stx) begin
						cmd.out_err_ld = 1'b1;
						cmd.err_code   = crcdf_pkg::ST_BAD_START;
					end else begin
						cmd.crc_op = crcdf_pkg::CRC_START;
						count_d    = '0;
						state_d    = S_LEN_LO;
					end
				end
			end
			S_LEN_LO: begin
				if (accept) begin
					cmd.crc_op    = crcdf_pkg::CRC_STEP;
					cmd.len_lo_ld = 1'b1;
					state_d       = S_LEN_HI;
				end
			end
			S_LEN_HI: begin
				if (accept) begin
					cmd.crc_op    = crcdf_pkg::CRC_STEP;
					cmd.len_hi_ld = 1'b1;
					cmd.rcrc_clr  = 1'b1;
					count_d       = '0;
					state_d       = S_HCRC;
				end
			end
			S_HCRC: begin
				if (accept) begin
					cmd.rcrc_ld = 1'b1;
					count_d     = count_q + 1'b1;
					if (count_q == crcdf_pkg::CNT_W'(3)) begin
						count_d = '0;
						if (!stat.hcrc_ok) begin
							cmd.out_err_ld = 1'b1;
							cmd.err_code   = crcdf_pkg::ST_HDR_CRC;
							state_d        = S_HUNT;
						end else if (!stat.len_ok) begin
							cmd.out_err_ld = 1'b1;
							cmd.err_code   = crcdf_pkg::ST_BAD_LEN;
							state_d        = S_HUNT;
						end else begin
							cmd.crc_op = crcdf_pkg::CRC_CLEAR;
							state_d    = S_DATA;
						end
					end
				end
			end
			S_DATA: begin
				if (accept) begin
					cmd.mem_wr = 1'b1;
					cmd.crc_op = crcdf_pkg::CRC_STEP;
					count_d    = count_q + 1'b1;
					if (stat.data_done) begin
						cmd.rcrc_clr = 1'b1;
						count_d      = '0;
						state_d      = S_DCRC;
					end
				end
			end
			S_DCRC: begin
				if (accept) begin
					cmd.rcrc_ld = 1'b1;
					count_d     = count_q + 1'b1;
					if (count_q == crcdf_pkg::CNT_W'(3)) begin
						state_d = S_ETX;
					end
				end
			end
			S_ETX: begin
				if (accept) begin
					count_d = '0;
					if (!stat.is_etx) begin
						cmd.out_err_ld = 1'b1;
						cmd.err_code   = crcdf_pkg::ST_BAD_END;
						state_d        = S_HUNT;
					end else if (!stat.dcrc_ok) begin
						cmd.out_err_ld = 1'b1;
						cmd.err_code   = crcdf_pkg::ST_DATA_CRC;
						state_d        = S_HUNT;
					end else begin
						state_d = S_REL_READ;
					end
				end
			end
			S_REL_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_REL_SEND;
			end
			S_REL_SEND: begin
				if (slot_free) begin
					cmd.out_data_ld = 1'b1;
					if (stat.rel_last) begin
						count_d = '0;
						state_d = S_HUNT;
					end else begin
						count_d = count_q + 1'b1;
						state_d = S_REL_READ;
					end
				end
			end
			default: begin
				count_d = '0;
				state_d = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_HUNT;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cmd.out_err_ld || cmd.out_data_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/crcdf_dpath.sv
// Deframer datapath: CRC accumulator, length and CRC capture, payload buffer, output register.
module crcdf_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        rx_byte,
	input  logic                              length_limit_we,
	input  logic [crcdf_pkg::LIMIT_W-1:0]     length_limit,
	input  crcdf_pkg::cmd_t                   cmd,
	output crcdf_pkg::stat_t                  stat,
	output logic [2:0]                        status,
	output logic [7:0]                        data_byte,
	output logic [5:0]                        payload_length,
	output logic                              last
);

	logic [crcdf_pkg::LIMIT_W-1:0] limit_q;
	logic [31:0]                   crc_q;
	logic [31:0]                   rcrc_q;
	logic [31:0]                   rcrc_merged;
	logic [crcdf_pkg::LEN_W-1:0]   len_q;
	logic [crcdf_pkg::LEN_W-1:0]   limit_eff;
	logic [crcdf_pkg::CNT_W-1:0]   count_inc;
	logic [7:0]                    mem [crcdf_pkg::MAX_PAYLOAD];
	logic [7:0]                    rd_q;
	crcdf_pkg::status_t            status_q;
	logic [7:0]                    data_q;
	logic [5:0]                    plen_q;
	logic                          last_q;

	assign rcrc_merged = rcrc_q | ({24'd0, rx_byte} << {cmd.count[1:0], 3'b000});
	assign count_inc   = cmd.count + 1'b1;
	assign limit_eff   = (crcdf_pkg::LEN_W'(limit_q) < crcdf_pkg::LEN_W'(crcdf_pkg::MAX_PAYLOAD)) ?
	                     crcdf_pkg::LEN_W'(limit_q) : crcdf_pkg::LEN_W'(crcdf_pkg::MAX_PAYLOAD);

	always_comb begin
		stat.is_stx    = (rx_byte == crcdf_pkg::STX_BYTE);
		stat.is_etx    = (rx_byte == crcdf_pkg::ETX_BYTE);
		stat.hcrc_ok   = (rcrc_merged == ~crc_q);
		stat.len_ok    = (len_q != '0) && (len_q <= limit_eff);
		stat.data_done = (crcdf_pkg::LEN_W'(count_inc) >= len_q);
		stat.dcrc_ok   = (rcrc_q == ~crc_q);
		stat.rel_last  = (count_inc == len_q[5:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= crcdf_pkg::LIMIT_RESET;
			crc_q   <= crcdf_pkg::CRC_INIT;
			rcrc_q  <= '0;
			len_q   <= '0;
		end else begin
			if (length_limit_we) begin
				limit_q <= length_limit;
			end
			case (cmd.crc_op)
				crcdf_pkg::CRC_START: crc_q <= crcdf_pkg::crc_byte(crcdf_pkg::CRC_INIT, rx_byte);
				crcdf_pkg::CRC_STEP:  crc_q <= crcdf_pkg::crc_byte(crc_q, rx_byte);
				crcdf_pkg::CRC_CLEAR: crc_q <= crcdf_pkg::CRC_INIT;
				default:              crc_q <= crc_q;
			endcase
			if (cmd.rcrc_clr) begin
				rcrc_q <= '0;
			end else if (cmd.rcrc_ld) begin
				rcrc_q <= rcrc_merged;
			end
			if (cmd.len_lo_ld) begin
				len_q <= {8'd0, rx_byte};
			end else if (cmd.len_hi_ld) begin
				len_q <= {rx_byte, len_q[7:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[cmd.count[crcdf_pkg::ADDR_W-1:0]] <= rx_byte;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[cmd.count[crcdf_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_err_ld) begin
			status_q <= cmd.err_code;
			data_q   <= '0;
			plen_q   <= '0;
			last_q   <= 1'b1;
		end else if (cmd.out_data_ld) begin
			status_q <= crcdf_pkg::ST_OK;
			data_q   <= rd_q;
			plen_q   <= len_q[5:0];
			last_q   <= stat.rel_last;
		end
	end

	assign status         = status_q;
	assign data_byte      = data_q;
	assign payload_length = plen_q;
	assign last           = last_q;

endmodule

>>> rtl/crc32c_packet_deframer_core.sv
// Results: an error result is presented the cycle after the byte that causes it; a good
// frame presents its first payload byte after its end byte, through the buffer read.
// Throughput: one received byte per cycle while parsing; a byte that may give a result waits
// for a free output slot. Payload release passes each byte through the registered buffer
// read, then into the output register, with input held off until the last byte is loaded.
// Reset: asynchronous, active low; hunts for the start byte, length limit 32, output empty.
module crc32c_packet_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          length_limit_we,
	input  logic [crcdf_pkg::LIMIT_W-1:0] length_limit,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [7:0]                    data_byte,
	output logic [5:0]                    payload_length,
	output logic                          last
);

	crcdf_pkg::cmd_t  cmd;
	crcdf_pkg::stat_t stat;

	crcdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	crcdf_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.length_limit_we (length_limit_we),
		.length_limit    (length_limit),
		.cmd             (cmd),
		.stat            (stat),
		.status          (status),
		.data_byte       (data_byte),
		.payload_length  (payload_length),
		.last            (last)
	);

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_err_ld && cmd.out_data_ld))
		else $error("error and data result loaded together");

	a_release_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_data_ld |-> !(in_valid && in_ready))
		else $error("item accepted during payload release");

	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != 3'(crcdf_pkg::ST_OK))) |->
		(last && (data_byte == 8'd0) && (payload_length == 6'd0)))
		else $error("error result not alone or carries data");

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_err_ld || cmd.out_data_ld) |-> (!out_valid || out_ready))
		else $error("result overwritten before taken");

endmodule

>>> tb/crc32c_packet_deframer_core_tb.sv
// Self-checking testbench for the CRC-32C STX/ETX packet deframer core.
module crc32c_packet_deframer_core_tb;

	typedef enum logic [2:0] {
		P_HUNT, P_LEN_LO, P_LEN_HI, P_HCRC, P_DATA, P_DCRC, P_ETX
	} rx_phase_t;

	typedef struct packed {
		crcdf_pkg::status_t code;
		logic [7:0]         data;
		logic [5:0]         plen;
		logic               fin;
	} result_t;

	localparam int F_NONE = 0;
	localparam int F_HDR  = 1;
	localparam int F_LEN  = 2;
	localparam int F_END  = 3;
	localparam int F_DCRC = 4;
	localparam int F_CUT  = 5;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          length_limit_we = 1'b0;
	logic [crcdf_pkg::LIMIT_W-1:0] length_limit = crcdf_pkg::LIMIT_RESET;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [7:0]                    rx_byte = 8'h00;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [2:0]                    status;
	logic [7:0]                    data_byte;
	logic [5:0]                    payload_length;
	logic                          last;

	crc32c_packet_deframer_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.length_limit_we(length_limit_we),
		.length_limit   (length_limit),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_byte      (data_byte),
		.payload_length (payload_length),
		.last           (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [7:0]   rx_stream[$];
	result_t      expected_results[$];
	int           bytes_queued = 0;
	int           mismatches = 0;
	logic         hold_sender = 1'b0;

	rx_phase_t    rx_state = P_HUNT;
	logic [5:0]   rx_count = '0;
	logic [15:0]  frame_len = '0;
	logic [31:0]  crc_run = crcdf_pkg::CRC_INIT;
	logic [31:0]  crc_seen = '0;
	logic [7:0]   payload_buf[crcdf_pkg::MAX_PAYLOAD];
	logic [5:0]   limit_model = crcdf_pkg::LIMIT_RESET;

	function automatic logic [31:0] crc32c_next(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'd0, b};
		repeat (8) r = (r >> 1) ^ (crcdf_pkg::CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	function automatic void flag_frame_error(input crcdf_pkg::status_t code);
		expected_results.push_back('{code: code, data: 8'h00, plen: 6'd0, fin: 1'b1});
		rx_state = P_HUNT;
		rx_count = '0;
	endfunction

	task automatic deframe_rx_byte(input logic [7:0] b);
		logic [5:0] lim;
		int n;
		case (rx_state)
			P_LEN_LO: begin
				frame_len = {8'h00, b};
				crc_run = crc32c_next(crc_run, b);
				rx_state = P_LEN_HI;
			end
			P_LEN_HI: begin
				frame_len[15:8] = b;
				crc_run = crc32c_next(crc_run, b);
				crc_seen = '0;
				rx_count = '0;
				rx_state = P_HCRC;
			end
			P_HCRC: begin
				crc_seen = crc_seen | ({24'd0, b} << (8 * rx_count[1:0]));
				rx_count = rx_count + 6'd1;
				if (rx_count >= 6'd4) begin
					lim = (limit_model < crcdf_pkg::MAX_PAYLOAD) ? limit_model :
						6'(crcdf_pkg::MAX_PAYLOAD);
					if (crc_seen != ~crc_run) begin
						flag_frame_error(crcdf_pkg::ST_HDR_CRC);
					end else if (frame_len == 16'd0 || frame_len > {10'd0, lim}) begin
						flag_frame_error(crcdf_pkg::ST_BAD_LEN);
					end else begin
						crc_run = crcdf_pkg::CRC_INIT;
						rx_count = '0;
						rx_state = P_DATA;
					end
				end
			end
			P_DATA: begin
				if (rx_count < crcdf_pkg::MAX_PAYLOAD)
					payload_buf[rx_count] = b;
				crc_run = crc32c_next(crc_run, b);
				rx_count = rx_count + 6'd1;
				if ({10'd0, rx_count} >= frame_len) begin
					crc_seen = '0;
					rx_count = '0;
					rx_state = P_DCRC;
				end
			end
			P_DCRC: begin
				crc_seen = crc_seen | ({24'd0, b} << (8 * rx_count[1:0]));
				rx_count = rx_count + 6'd1;
				if (rx_count >= 6'd4)
					rx_state = P_ETX;
			end
			P_ETX: begin
				if (b != crcdf_pkg::ETX_BYTE) begin
					flag_frame_error(crcdf_pkg::ST_BAD_END);
				end else if (crc_seen != ~crc_run) begin
					flag_frame_error(crcdf_pkg::ST_DATA_CRC);
				end else begin
					n = (frame_len < crcdf_pkg::MAX_PAYLOAD) ? int'(frame_len) :
						crcdf_pkg::MAX_PAYLOAD;
					for (int i = 0; i < n; i++)
						expected_results.push_back('{code: crcdf_pkg::ST_OK,
							data: payload_buf[i], plen: 6'(n), fin: (i == n - 1)});
					rx_state = P_HUNT;
					rx_count = '0;
				end
			end
			default: begin
				if (b != crcdf_pkg::STX_BYTE) begin
					flag_frame_error(crcdf_pkg::ST_BAD_START);
				end else begin
					crc_run = crc32c_next(crcdf_pkg::CRC_INIT, b);
					frame_len = '0;
					rx_count = '0;
					rx_state = P_LEN_LO;
				end
			end
		endcase
	endtask

	// predict on every accepted item, check every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				deframe_rx_byte(rx_byte);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none, %s %0d %0h %0d %0b",
						$time, "actual status/data/len/last", status, data_byte,
						payload_length, last);
					mismatches++;
				end else begin
					if (status !== expected_results[0].code) begin
						$display("%0t status: expected %0d actual %0d",
							$time, expected_results[0].code, status);
						mismatches++;
					end
					if (data_byte !== expected_results[0].data) begin
						$display("%0t data_byte: expected %02h actual %02h",
							$time, expected_results[0].data, data_byte);
						mismatches++;
					end
					if (payload_length !== expected_results[0].plen) begin
						$display("%0t payload_length: expected %0d actual %0d",
							$time, expected_results[0].plen, payload_length);
						mismatches++;
					end
					if (last !== expected_results[0].fin) begin
						$display("%0t last: expected %0b actual %0b",
							$time, expected_results[0].fin, last);
						mismatches++;
					end
					void'(expected_results.pop_front());
				end
			end
		end
	end

	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				void'(rx_stream.pop_front());
				if (burst_left > 0)
					burst_left--;
			end
			// hold the item until it is taken
			if (!(in_valid && !in_ready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (hold_sender || rx_stream.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte <= rx_stream[0];
				end
			end
		end
	end

	logic [10:0] ready_pattern = 11'b10110011101;
	int          ready_mode = 0;
	int          mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 80);
			end
			mode_left--;
			ready_pattern = {ready_pattern[9:0], ready_pattern[10]};
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ready_pattern[0];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic void push_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void push_frame(input logic [15:0] len, input int flaw);
		logic [7:0]  fr[$];
		logic [31:0] c;
		logic [7:0]  b;
		int          cut;
		fr.push_back(crcdf_pkg::STX_BYTE);
		fr.push_back(len[7:0]);
		fr.push_back(len[15:8]);
		c = crcdf_pkg::CRC_INIT;
		foreach (fr[i])
			c = crc32c_next(c, fr[i]);
		c = ~c;
		if (flaw == F_HDR)
			c = c ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			fr.push_back(c[8*i +: 8]);
		if (flaw != F_HDR && flaw != F_LEN) begin
			c = crcdf_pkg::CRC_INIT;
			for (int i = 0; i < int'(len); i++) begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				fr.push_back(b);
				c = crc32c_next(c, b);
			end
			c = ~c;
			if (flaw == F_DCRC)
				c = c ^ (32'd1 << $urandom_range(0, 31));
			for (int i = 0; i < 4; i++)
				fr.push_back(c[8*i +: 8]);
			if (flaw == F_END) begin
				do b = 8'($urandom_range(0, 255)); while (b == crcdf_pkg::ETX_BYTE);
				fr.push_back(b);
			end else begin
				fr.push_back(crcdf_pkg::ETX_BYTE);
			end
		end
		cut = (flaw == F_CUT) ? $urandom_range(1, fr.size() - 1) : fr.size();
		for (int i = 0; i < cut; i++)
			push_byte(fr[i]);
	endfunction

	function automatic logic [15:0] pick_good_len(input int lim_eff);
		int top;
		int r;
		top = (lim_eff == 0) ? 1 : lim_eff;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(1, (top < 8) ? top : 8));
		else if (r < 9)
			return 16'($urandom_range(1, top));
		return 16'(top);
	endfunction

	function automatic logic [15:0] pick_bad_len(input int lim_eff);
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'(lim_eff + 1);
			2: return 16'($urandom_range(lim_eff + 1, 255));
			default: return {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
		endcase
	endfunction

	task automatic gen_traffic(input int n_bytes);
		int start;
		int roll;
		int lim_eff;
		start = bytes_queued;
		lim_eff = (limit_model < crcdf_pkg::MAX_PAYLOAD) ? int'(limit_model) :
			crcdf_pkg::MAX_PAYLOAD;
		while (bytes_queued - start < n_bytes) begin
			roll = $urandom_range(0, 99);
			if (roll < 52)
				push_frame(pick_good_len(lim_eff), F_NONE);
			else if (roll < 60)
				push_frame(pick_good_len(lim_eff), F_HDR);
			else if (roll < 70)
				push_frame(pick_bad_len(lim_eff), F_LEN);
			else if (roll < 78)
				push_frame(pick_good_len(lim_eff), F_END);
			else if (roll < 87)
				push_frame(pick_good_len(lim_eff), F_DCRC);
			else if (roll < 93)
				push_frame(pick_good_len(lim_eff), F_CUT);
			else
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (rx_stream.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic drain_to_hunt();
		wait_idle();
		while (rx_state != P_HUNT) begin
			push_byte(8'hFF);
			wait_idle();
		end
	endtask

	task automatic write_length_limit(input logic [5:0] v);
		@(posedge clk);
		length_limit_we <= 1'b1;
		length_limit <= v;
		@(posedge clk);
		length_limit_we <= 1'b0;
		limit_model = v;
		@(negedge clk);
	endtask

	initial begin
		push_byte(8'h00);
		push_byte(8'hFF);
		push_frame(16'd1, F_NONE);
		push_frame(16'd5, F_HDR);
		push_frame(16'd0, F_LEN);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_frame(16'd32, F_NONE);
		gen_traffic(45);
		drain_to_hunt();

		write_length_limit(6'd7);
		gen_traffic(25);
		while (rx_stream.size() > 25) @(negedge clk);
		hold_sender = 1'b1;
		do @(negedge clk); while (in_valid || expected_results.size() != 0);
		repeat (3) @(negedge clk);
		hold_sender = 1'b0;
		drain_to_hunt();

		write_length_limit(6'd1);
		gen_traffic(18);
		drain_to_hunt();

		write_length_limit(6'd0);
		gen_traffic(12);
		drain_to_hunt();

		write_length_limit(6'd63);
		push_frame(16'd32, F_NONE);
		push_frame(16'd33, F_LEN);
		gen_traffic(25);
		drain_to_hunt();

		write_length_limit(6'($urandom_range(2, 31)));
		gen_traffic(20);
		drain_to_hunt();

		repeat (16) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t missing results: expected %0d more, actual 0",
				$time, expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
